FILE: rtl/lsa_pkg.sv
package lsa_pkg;

    // list and field sizes
    localparam int unsigned ROWS_MAX  = 4096;
    localparam int unsigned ROWS_LIM  = (ROWS_MAX < 4096) ? ROWS_MAX : 4096;
    localparam int unsigned SEL_W     = 12;
    localparam int unsigned ROWS_W    = 13;
    localparam int unsigned DELAY_W   = 12;
    localparam int unsigned PERIOD_W  = 10;
    localparam int unsigned VIS_W     = 7;
    localparam int unsigned DT_W      = 8;
    localparam int unsigned ACC_W     = 13;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned MOVES_W   = 11;
    localparam int unsigned PADDR_W   = 4;

    localparam logic [MOVES_W-1:0] MOVES_MAX = '1;

    // register reset values
    localparam logic [ROWS_W-1:0]   ROW_COUNT_RST     = 13'd0;
    localparam logic [DELAY_W-1:0]  REPEAT_DELAY_RST  = 12'd500;
    localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST = 10'd100;
    localparam logic [VIS_W-1:0]    VISIBLE_ROWS_RST  = 7'd16;

    // register indexes
    typedef enum logic [1:0] {
        REG_ROW_COUNT     = 2'd0,
        REG_REPEAT_DELAY  = 2'd1,
        REG_REPEAT_PERIOD = 2'd2,
        REG_VISIBLE_ROWS  = 2'd3
    } t_reg_idx;

    // request commands
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_PRESS   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_WRITE   = 2'd3
    } t_cmd;

    // scroll keys
    typedef enum logic [1:0] {
        KEY_DOWN      = 2'd0,
        KEY_UP        = 2'd1,
        KEY_PAGE_DOWN = 2'd2,
        KEY_PAGE_UP   = 2'd3
    } t_key;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADD2,
        ST_LOOP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ROWS_W-1:0]   row_count;
        logic [DELAY_W-1:0]  repeat_delay;
        logic [PERIOD_W-1:0] repeat_period;
        logic [VIS_W-1:0]    visible_rows;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic apply;
        logic accum1;
        logic accum2;
        logic loop_step;
        logic load_out;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic step_zero;
        logic will_repeat;
        logic acc_ge_period;
        logic out_free;
    } t_dp_sts;

    // signed step for each key
    function automatic logic signed [STEP_W-1:0] key_step(input t_key k);
        logic signed [STEP_W-1:0] s;
        case (k)
            KEY_DOWN:      s = 5'sd1;
            KEY_UP:        s = -5'sd1;
            KEY_PAGE_DOWN: s = 5'sd10;
            KEY_PAGE_UP:   s = -5'sd10;
            default:       s = 5'sd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/lsa_in_if.sv
interface lsa_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [1:0]                     key;
    logic [lsa_pkg::DT_W-1:0]       delta_time;
    logic [lsa_pkg::SEL_W-1:0]      new_selection;

    modport source (output valid, cmd, key, delta_time, new_selection, input ready);
    modport sink   (input valid, cmd, key, delta_time, new_selection, output ready);
endinterface

FILE: rtl/lsa_out_if.sv
interface lsa_out_if;
    logic                           valid;
    logic                           ready;
    logic [lsa_pkg::SEL_W-1:0]      selection;
    logic [lsa_pkg::SEL_W-1:0]      first_visible;
    logic                           held;
    logic [lsa_pkg::MOVES_W-1:0]    move_count;

    modport source (output valid, selection, first_visible, held, move_count, input ready);
    modport sink   (input valid, selection, first_visible, held, move_count, output ready);
endinterface

FILE: rtl/lsa_cfg.sv
module lsa_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsa_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output lsa_pkg::t_cfg                 o_cfg
);

    lsa_pkg::t_cfg    r_cfg;
    lsa_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = lsa_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count     <= lsa_pkg::ROW_COUNT_RST;
            r_cfg.repeat_delay  <= lsa_pkg::REPEAT_DELAY_RST;
            r_cfg.repeat_period <= lsa_pkg::REPEAT_PERIOD_RST;
            r_cfg.visible_rows  <= lsa_pkg::VISIBLE_ROWS_RST;
        end else if (w_wr) begin
            case (w_idx)
                lsa_pkg::REG_ROW_COUNT:
                    r_cfg.row_count <= pwdata[lsa_pkg::ROWS_W-1:0];
                lsa_pkg::REG_REPEAT_DELAY:
                    r_cfg.repeat_delay <= pwdata[lsa_pkg::DELAY_W-1:0];
                lsa_pkg::REG_REPEAT_PERIOD:
                    r_cfg.repeat_period <= pwdata[lsa_pkg::PERIOD_W-1:0];
                lsa_pkg::REG_VISIBLE_ROWS:
                    r_cfg.visible_rows <= pwdata[lsa_pkg::VIS_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            lsa_pkg::REG_ROW_COUNT:
                prdata[lsa_pkg::ROWS_W-1:0] = r_cfg.row_count;
            lsa_pkg::REG_REPEAT_DELAY:
                prdata[lsa_pkg::DELAY_W-1:0] = r_cfg.repeat_delay;
            lsa_pkg::REG_REPEAT_PERIOD:
                prdata[lsa_pkg::PERIOD_W-1:0] = r_cfg.repeat_period;
            lsa_pkg::REG_VISIBLE_ROWS:
                prdata[lsa_pkg::VIS_W-1:0] = r_cfg.visible_rows;
            default: prdata = '0;
        endcase
    end

endmodule

FILE: rtl/lsa_ctrl.sv
module lsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lsa_pkg::t_dp_sts    i_sts,
    output lsa_pkg::t_dp_ctl    o_ctl
);

    lsa_pkg::t_state r_state;
    lsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsa_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lsa_pkg::ST_EXEC;
            end
            lsa_pkg::ST_EXEC: begin
                if (i_sts.is_tick && !i_sts.step_zero && i_sts.will_repeat) begin
                    n_state = lsa_pkg::ST_ADD2;
                end else begin
                    n_state = lsa_pkg::ST_DONE;
                end
            end
            lsa_pkg::ST_ADD2: n_state = lsa_pkg::ST_LOOP;
            lsa_pkg::ST_LOOP: begin
                if (!i_sts.acc_ge_period) n_state = lsa_pkg::ST_DONE;
            end
            lsa_pkg::ST_DONE: begin
                if (i_sts.out_free) n_state = lsa_pkg::ST_IDLE;
            end
            default: n_state = lsa_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_ctl      = '0;
        case (r_state)
            lsa_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.latch = i_in_valid;
            end
            lsa_pkg::ST_EXEC: begin
                if (i_sts.is_tick) begin
                    o_ctl.accum1 = !i_sts.step_zero;
                end else begin
                    o_ctl.apply = 1'b1;
                end
            end
            lsa_pkg::ST_ADD2: o_ctl.accum2 = 1'b1;
            lsa_pkg::ST_LOOP: o_ctl.loop_step = i_sts.acc_ge_period;
            lsa_pkg::ST_DONE: o_ctl.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/lsa_dp.sv
module lsa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsa_pkg::t_cfg                 i_cfg,
    input  lsa_pkg::t_dp_ctl              i_ctl,
    output lsa_pkg::t_dp_sts              o_sts,
    input  logic [1:0]                    i_cmd,
    input  logic [1:0]                    i_key,
    input  logic [lsa_pkg::DT_W-1:0]      i_delta_time,
    input  logic [lsa_pkg::SEL_W-1:0]     i_new_selection,
    lsa_out_if.source                     o_rsp
);

    // latched request
    lsa_pkg::t_cmd                 r_cmd;
    lsa_pkg::t_key                 r_key;
    logic [lsa_pkg::DT_W-1:0]      r_dt;
    logic [lsa_pkg::SEL_W-1:0]     r_new_sel;

    // cursor state
    logic [lsa_pkg::SEL_W-1:0]     r_sel, n_sel;
    logic signed [lsa_pkg::STEP_W-1:0] r_step, n_step;
    logic                          r_rep, n_rep;
    logic [lsa_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic [lsa_pkg::MOVES_W-1:0]   r_moves, n_moves;

    // result register
    logic                          r_out_valid;
    logic [lsa_pkg::SEL_W-1:0]     r_out_sel;
    logic [lsa_pkg::SEL_W-1:0]     r_out_first;
    logic                          r_out_held;
    logic [lsa_pkg::MOVES_W-1:0]   r_out_moves;

    logic [lsa_pkg::ROWS_W-1:0]    w_rows;
    logic                          w_rows_zero;
    logic [lsa_pkg::PERIOD_W-1:0]  w_period;
    logic [lsa_pkg::VIS_W-1:0]     w_vis;
    logic [lsa_pkg::ACC_W:0]       w_acc_dt;
    logic                          w_ge_delay;
    logic                          w_ge_period;
    logic signed [lsa_pkg::STEP_W-1:0] w_step;
    logic signed [13:0]            w_s0, w_s1, w_s2, w_rows_s;
    logic [lsa_pkg::SEL_W-1:0]     w_moved;
    logic signed [13:0]            w_st, w_lim;
    logic [lsa_pkg::SEL_W-1:0]     w_first;
    logic                          w_out_free;

    // effective configuration
    assign w_rows = (i_cfg.row_count > lsa_pkg::ROWS_W'(lsa_pkg::ROWS_LIM))
                  ? lsa_pkg::ROWS_W'(lsa_pkg::ROWS_LIM) : i_cfg.row_count;
    assign w_rows_zero = (w_rows == '0);
    assign w_period = (i_cfg.repeat_period == '0) ? lsa_pkg::PERIOD_W'(1)
                    : i_cfg.repeat_period;
    assign w_vis = (i_cfg.visible_rows == '0) ? lsa_pkg::VIS_W'(1) : i_cfg.visible_rows;

    // timing compares
    assign w_acc_dt    = {1'b0, r_acc} + (lsa_pkg::ACC_W+1)'(r_dt);
    assign w_ge_delay  = w_acc_dt >= (lsa_pkg::ACC_W+1)'(i_cfg.repeat_delay);
    assign w_ge_period = r_acc >= lsa_pkg::ACC_W'(w_period);

    // step for the move: a press moves with its new step at once
    assign w_step = (i_ctl.apply && (r_cmd == lsa_pkg::CMD_PRESS))
                  ? lsa_pkg::key_step(r_key) : r_step;

    // one step with wrap for single steps and clamp for page steps
    always_comb begin
        w_rows_s = 14'(signed'({1'b0, w_rows}));
        w_s0 = signed'(14'({2'b00, r_sel})) + 14'(w_step);
        w_s1 = w_s0;
        if (w_s0 < 0) begin
            w_s1 = (w_step < -5'sd1) ? 14'sd0 : w_s0 + w_rows_s;
        end
        w_s2 = w_s1;
        if (w_s1 >= w_rows_s) begin
            w_s2 = (w_step > 5'sd1) ? w_rows_s - 14'sd1 : w_s1 - w_rows_s;
        end
        w_moved = w_s2[lsa_pkg::SEL_W-1:0];
    end

    // visible window start
    always_comb begin
        w_lim   = 14'(signed'({1'b0, w_rows})) - 14'(signed'({1'b0, w_vis}));
        w_st    = signed'(14'({2'b00, r_sel})) - 14'(signed'({1'b0, w_vis[lsa_pkg::VIS_W-1:1]}));
        w_first = '0;
        if (w_lim >= 0) begin
            if (w_st < 0) w_st = 14'sd0;
            if (w_st >= w_lim) w_st = w_lim;
            w_first = w_st[lsa_pkg::SEL_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign o_sts.is_tick       = (r_cmd == lsa_pkg::CMD_TICK);
    assign o_sts.step_zero     = (r_step == '0);
    assign o_sts.will_repeat   = r_rep || w_ge_delay;
    assign o_sts.acc_ge_period = w_ge_period;
    assign o_sts.out_free      = w_out_free;

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd     <= lsa_pkg::t_cmd'(i_cmd);
            r_key     <= lsa_pkg::t_key'(i_key);
            r_dt      <= i_delta_time;
            r_new_sel <= i_new_selection;
        end
    end

    // cursor state update
    always_comb begin
        n_sel   = r_sel;
        n_step  = r_step;
        n_rep   = r_rep;
        n_acc   = r_acc;
        n_moves = r_moves;
        if (i_ctl.latch) begin
            n_moves = '0;
        end
        if (i_ctl.apply) begin
            case (r_cmd)
                lsa_pkg::CMD_PRESS: begin
                    if (!w_rows_zero) begin
                        n_step  = w_step;
                        n_sel   = w_moved;
                        n_moves = lsa_pkg::MOVES_W'(1);
                    end
                end
                lsa_pkg::CMD_RELEASE: begin
                    if (!w_rows_zero) begin
                        n_step = '0;
                        n_rep  = 1'b0;
                        n_acc  = '0;
                    end
                end
                lsa_pkg::CMD_WRITE: n_sel = r_new_sel;
                default: ;
            endcase
        end
        if (i_ctl.accum1) begin
            if (!r_rep && w_ge_delay) begin
                n_acc = lsa_pkg::ACC_W'(w_period);
                n_rep = 1'b1;
            end else begin
                n_acc = w_acc_dt[lsa_pkg::ACC_W-1:0];
            end
        end
        if (i_ctl.accum2) begin
            n_acc = w_acc_dt[lsa_pkg::ACC_W-1:0];
        end
        if (i_ctl.loop_step) begin
            n_acc = r_acc - lsa_pkg::ACC_W'(w_period);
            if (!w_rows_zero) begin
                n_sel = w_moved;
                if (r_moves != lsa_pkg::MOVES_MAX) n_moves = r_moves + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= '0;
            r_step  <= '0;
            r_rep   <= 1'b0;
            r_acc   <= '0;
            r_moves <= '0;
        end else begin
            r_sel   <= n_sel;
            r_step  <= n_step;
            r_rep   <= n_rep;
            r_acc   <= n_acc;
            r_moves <= n_moves;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_sel   <= r_sel;
            r_out_first <= w_first;
            r_out_held  <= (r_step != '0);
            r_out_moves <= r_moves;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.selection     = r_out_sel;
    assign o_rsp.first_visible = r_out_first;
    assign o_rsp.held          = r_out_held;
    assign o_rsp.move_count    = r_out_moves;

endmodule

FILE: rtl/list_selection_autorepeat.sv
// menu cursor with key auto-repeat
// requests come in on i_req: cmd selects tick, key press, key release or
// selection write; key, delta_time and new_selection ride along.
// every request gives exactly one result on o_rsp: selection, first
// visible row of the window, held flag and the number of moves made.
// registers (row_count, repeat_delay, repeat_period, visible_rows) sit on
// the APB port at byte offsets 0, 4, 8 and 12; write them only while idle.
// press, release, write and ticks that do not repeat pass from accept through
// the execute and done states to the result register; a new request is taken
// only once the done state has returned to idle. a tick that repeats passes
// the add and repeat loop states between execute and done; the repeat loop makes
// one move per cycle, so its length follows the accumulated time over the period.
// one request is in work at a time; i_req.ready is high only while idle.
// the result register lets the next request be accepted while a result
// waits; a stalled receiver holds the block in its final step until taken.
// reset clears the cursor, the held step, repeat state, the accumulator and
// the move count and the result valid flag, and loads the register defaults.
module list_selection_autorepeat (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsa_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    lsa_in_if.sink                        i_req,
    lsa_out_if.source                     o_rsp
);

    lsa_pkg::t_cfg    w_cfg;
    lsa_pkg::t_dp_ctl w_ctl;
    lsa_pkg::t_dp_sts w_sts;

    // configuration registers
    lsa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencing
    lsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // cursor arithmetic and result register
    lsa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_cmd           (i_req.cmd),
        .i_key           (i_req.key),
        .i_delta_time    (i_req.delta_time),
        .i_new_selection (i_req.new_selection),
        .o_rsp           (o_rsp)
    );

endmodule
